[hdl/cwtkd_pkg.sv]
// shared constants, types and register codes of the cw tone keying detector
package cwtkd_pkg;

    localparam int EXTRA_FRACTION = 16;
    localparam int COUNT_WIDTH    = 16;
    localparam int FRAC_BITS      = 8 + EXTRA_FRACTION;

    // level input widened to the internal fraction, and the working width of sums
    localparam int LEVEL_W = 16 + EXTRA_FRACTION;
    localparam int ACC_W   = ((LEVEL_W > 32) ? LEVEL_W : 32) + 3;

    localparam int MARGIN_W  = 15;
    localparam int ELAPSED_W = 16;
    localparam int CFG_IDX_W = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ENABLE     = 2'd0,
        REG_SNR_MARGIN = 2'd1,
        REG_HYSTERESIS = 2'd2
    } cwtkd_reg_t;

    localparam logic [MARGIN_W-1:0] SNR_MARGIN_RESET = 15'd2560;
    localparam logic [MARGIN_W-1:0] HYSTERESIS_RESET = 15'd768;

    typedef struct packed {
        logic [MARGIN_W-1:0] snr_margin;
        logic [MARGIN_W-1:0] hysteresis;
    } cwtkd_cfg_t;

    // whole dB value in the internal fixed point, clamped to 32 bits
    function automatic logic signed [31:0] db_const(input longint db);
        longint v;
        v = db * (longint'(1) << FRAC_BITS);
        if (v > longint'(32'sh7fffffff)) begin
            return 32'sh7fffffff;
        end else if (v < -longint'(64'h80000000)) begin
            return 32'sh80000000;
        end
        return 32'(v);
    endfunction

    localparam logic signed [31:0] SIG_AVG_RESET   = db_const(-121);
    localparam logic signed [31:0] NOISE_AVG_RESET = db_const(-73);
    localparam logic signed [31:0] BOUND_RESET     = db_const(50);

endpackage

[hdl/cwtkd_level_pipe.sv]
// level averaging, bound tracking and keying decision pipeline
module cwtkd_level_pipe
    import cwtkd_pkg::*;
(
    input  logic                        aclk,
    input  logic                        aresetn,
    input  cwtkd_cfg_t                  cfg,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic signed [15:0]          in_signal,
    input  logic signed [15:0]          in_noise,
    input  logic [ELAPSED_W-1:0]        in_elapsed,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic                        out_key_on,
    output logic [ELAPSED_W-1:0]        out_elapsed
);

    localparam int PROD_W = ACC_W + 13;
    localparam logic signed [12:0] COEF_FAST = 13'sd3277;
    localparam logic signed [12:0] COEF_SLOW = 13'sd66;
    localparam int COEF_SHIFT = 16;

    function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] v);
        if ((&v[ACC_W-1:31]) || !(|v[ACC_W-1:31])) begin
            return v[31:0];
        end
        return v[ACC_W-1] ? 32'sh80000000 : 32'sh7fffffff;
    endfunction

    // cur + floor((target - cur) * coef / 2^16), saturated
    function automatic logic signed [31:0] track(
        input logic signed [31:0]      cur,
        input logic signed [ACC_W-1:0] target,
        input logic                    fast
    );
        logic signed [ACC_W-1:0]  delta;
        logic signed [PROD_W-1:0] prod;
        logic signed [PROD_W-1:0] coef;
        logic signed [PROD_W-1:0] shifted;
        delta   = target - ACC_W'(cur);
        coef    = PROD_W'(fast ? COEF_FAST : COEF_SLOW);
        prod    = PROD_W'(delta) * coef;
        shifted = prod >>> COEF_SHIFT;
        return sat32(ACC_W'(cur) + shifted[ACC_W-1:0]);
    endfunction

    // stage a: captured report
    logic                 a_valid_reg, a_valid_next;
    logic signed [15:0]   a_signal_reg;
    logic signed [15:0]   a_noise_reg;
    logic [ELAPSED_W-1:0] a_elapsed_reg;

    // stage b: averages
    logic                 b_valid_reg, b_valid_next;
    logic [ELAPSED_W-1:0] b_elapsed_reg;
    logic signed [31:0]   sig_avg_reg, sig_avg_next;
    logic signed [31:0]   noise_avg_reg, noise_avg_next;

    // stage c: bounds
    logic                    c_valid_reg, c_valid_next;
    logic [ELAPSED_W-1:0]    c_elapsed_reg;
    logic signed [ACC_W-1:0] c_aligned_reg, c_aligned_next;
    logic signed [31:0]      low_reg, low_next;
    logic signed [31:0]      high_reg, high_next;

    // stage d: key state, also the result register
    logic                 d_valid_reg, d_valid_next;
    logic [ELAPSED_W-1:0] d_elapsed_reg;
    logic                 tone_reg, tone_next;

    logic a_ready, b_ready, c_ready, d_ready;
    logic a_load, b_load, c_load, d_load;

    logic signed [ACC_W-1:0] sig_in_ext, sig_delta, sig_sum;
    logic signed [ACC_W-1:0] noise_in_ext;
    logic signed [ACC_W-1:0] low_ext, high_ext, mid, on_th, on_margin, off_th;

    assign d_ready = !d_valid_reg || out_ready;
    assign c_ready = !c_valid_reg || d_ready;
    assign b_ready = !b_valid_reg || c_ready;
    assign a_ready = !a_valid_reg || b_ready;

    assign a_load = in_valid && a_ready;
    assign b_load = a_valid_reg && b_ready;
    assign c_load = b_valid_reg && c_ready;
    assign d_load = c_valid_reg && d_ready;

    assign in_ready = a_ready;

    always_comb begin
        a_valid_next = a_load ? 1'b1 : (b_load ? 1'b0 : a_valid_reg);
        b_valid_next = b_load ? 1'b1 : (c_load ? 1'b0 : b_valid_reg);
        c_valid_next = c_load ? 1'b1 : (d_load ? 1'b0 : c_valid_reg);
        d_valid_next = d_load ? 1'b1 : ((d_valid_reg && out_ready) ? 1'b0 : d_valid_reg);
    end

    // averages from the stage a report
    always_comb begin
        sig_in_ext     = ACC_W'(a_signal_reg) <<< EXTRA_FRACTION;
        noise_in_ext   = ACC_W'(a_noise_reg) <<< EXTRA_FRACTION;
        sig_delta      = sig_in_ext - ACC_W'(sig_avg_reg);
        sig_sum        = ACC_W'(sig_avg_reg) + (sig_delta >>> 1);
        sig_avg_next   = sat32(sig_sum);
        noise_avg_next = track(noise_avg_reg, noise_in_ext, 1'b1);
    end

    // bounds move fast toward a new extreme
    always_comb begin
        c_aligned_next = ACC_W'(sig_avg_reg) - ACC_W'(noise_avg_reg);
        low_next  = track(low_reg, c_aligned_next, ACC_W'(low_reg) > c_aligned_next);
        high_next = track(high_reg, c_aligned_next, ACC_W'(high_reg) < c_aligned_next);
    end

    // thresholds and hysteresis
    always_comb begin
        low_ext   = ACC_W'(low_reg);
        high_ext  = ACC_W'(high_reg);
        on_margin = low_ext + (signed'(ACC_W'(cfg.snr_margin)) <<< EXTRA_FRACTION);
        mid       = (low_ext + high_ext) >>> 1;
        on_th     = (mid > on_margin) ? mid : on_margin;
        off_th    = on_th - (signed'(ACC_W'(cfg.hysteresis)) <<< EXTRA_FRACTION);
        if (tone_reg) begin
            tone_next = !(c_aligned_reg < off_th);
        end else begin
            tone_next = c_aligned_reg > on_th;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg   <= 1'b0;
            b_valid_reg   <= 1'b0;
            c_valid_reg   <= 1'b0;
            d_valid_reg   <= 1'b0;
            sig_avg_reg   <= SIG_AVG_RESET;
            noise_avg_reg <= NOISE_AVG_RESET;
            low_reg       <= BOUND_RESET;
            high_reg      <= BOUND_RESET;
            tone_reg      <= 1'b0;
        end else begin
            a_valid_reg <= a_valid_next;
            b_valid_reg <= b_valid_next;
            c_valid_reg <= c_valid_next;
            d_valid_reg <= d_valid_next;
            if (b_load) begin
                sig_avg_reg   <= sig_avg_next;
                noise_avg_reg <= noise_avg_next;
            end
            if (c_load) begin
                low_reg  <= low_next;
                high_reg <= high_next;
            end
            if (d_load) begin
                tone_reg <= tone_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (a_load) begin
            a_signal_reg  <= in_signal;
            a_noise_reg   <= in_noise;
            a_elapsed_reg <= in_elapsed;
        end
        if (b_load) begin
            b_elapsed_reg <= a_elapsed_reg;
        end
        if (c_load) begin
            c_elapsed_reg <= b_elapsed_reg;
            c_aligned_reg <= c_aligned_next;
        end
        if (d_load) begin
            d_elapsed_reg <= c_elapsed_reg;
        end
    end

    assign out_valid   = d_valid_reg;
    assign out_key_on  = tone_reg;
    assign out_elapsed = d_elapsed_reg;

endmodule

[hdl/cw_tone_keying_detector_top.sv]
// top level of the cw tone keying detector
//
// s_ channel: one beat per audio sample. s_tlast marks a sample that closes
// a level report; s_tdata carries the signal and noise levels (signed Q8.8 dB).
// m_ channel: one beat per report, with the key state and the number of
// samples seen since the previous report (saturating at 65535).
// cfg_ channel: register writes, always ready; index 0 enable, 1 snr margin,
// 2 hysteresis. Write only while no report is in flight.
// Throughput: one sample per cycle, back to back, reports included, while m_tready
// keeps the pipeline from filling. A report passes the capture register, then the
// averages, the bounds and the key decision stages, the last stage being the
// output register that drives m_tvalid.
// Non-report samples only advance the sample counter and give no beat.
// With enable low every beat is taken and dropped, with no state change.
// When m_tready is low, results queue in the four pipeline stages; s_tready
// drops only once all of them are full.
// Reset: averages at -121 and -73 dB, bounds at 50 dB, key off, counter
// zero, enable on, margin 10 dB, hysteresis 3 dB.
module cw_tone_keying_detector_top
    import cwtkd_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [31:0]          s_tdata,   // signal_level [15:0], noise_level [31:16]
    input  logic                 s_tlast,   // report
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [23:0]          m_tdata,   // key_on [0], elapsed_samples [16:1], zero [23:17]
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [MARGIN_W-1:0]  cfg_data
);

    localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;

    logic                   enable_reg;
    cwtkd_cfg_t             cfg_reg;
    logic [COUNT_WIDTH-1:0] count_reg, count_next;
    logic [ELAPSED_W-1:0]   elapsed;
    logic                   pipe_in_ready;
    logic                   pipe_in_valid;
    logic                   take;
    logic                   key_on;
    logic [ELAPSED_W-1:0]   out_elapsed;
    logic [COUNT_WIDTH+ELAPSED_W-1:0] count_wide;

    assign cfg_ready = 1'b1;
    assign s_tready  = !enable_reg || pipe_in_ready;
    assign take      = s_tvalid && s_tready && enable_reg;
    assign pipe_in_valid = take && s_tlast;

    always_comb begin
        count_wide = (COUNT_WIDTH + ELAPSED_W)'(count_reg);
        if (count_wide > (COUNT_WIDTH + ELAPSED_W)'({ELAPSED_W{1'b1}})) begin
            elapsed = '1;
        end else begin
            elapsed = count_wide[ELAPSED_W-1:0];
        end
        // count the report sample itself after emitting
        if (s_tlast) begin
            count_next = COUNT_WIDTH'(1);
        end else if (count_reg == CNT_MAX) begin
            count_next = count_reg;
        end else begin
            count_next = count_reg + COUNT_WIDTH'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enable_reg         <= 1'b1;
            cfg_reg.snr_margin <= SNR_MARGIN_RESET;
            cfg_reg.hysteresis <= HYSTERESIS_RESET;
            count_reg          <= '0;
        end else begin
            if (cfg_valid) begin
                unique case (cfg_index)
                    REG_ENABLE:     enable_reg         <= cfg_data[0];
                    REG_SNR_MARGIN: cfg_reg.snr_margin <= cfg_data;
                    REG_HYSTERESIS: cfg_reg.hysteresis <= cfg_data;
                    default: ;
                endcase
            end
            if (take) begin
                count_reg <= count_next;
            end
        end
    end

    cwtkd_level_pipe u_level_pipe (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg_reg),
        .in_valid    (pipe_in_valid),
        .in_ready    (pipe_in_ready),
        .in_signal   (signed'(s_tdata[15:0])),
        .in_noise    (signed'(s_tdata[31:16])),
        .in_elapsed  (elapsed),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_key_on  (key_on),
        .out_elapsed (out_elapsed)
    );

    assign m_tdata = {7'b0, out_elapsed, key_on};

    // a report restarts the count at one
    a_report_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        (take && s_tlast) |=> (count_reg == COUNT_WIDTH'(1)))
        else $error("sample count not restarted by report");

    // the counter sticks at its maximum
    a_count_saturates: assert property (@(posedge aclk) disable iff (!aresetn)
        (take && !s_tlast && count_reg == CNT_MAX) |=> (count_reg == CNT_MAX))
        else $error("sample count wrapped");

    // while disabled nothing is counted
    a_disabled_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (!enable_reg && !cfg_valid) |=> $stable(count_reg))
        else $error("counter moved while disabled");

endmodule

[test/cwtkd_checker.sv]
`timescale 1ns / 100ps
// checker of the cw tone keying detector: watches all channels, predicts and compares results
module cwtkd_checker
    import cwtkd_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [31:0]          s_tdata,
    input  logic                 s_tlast,
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [23:0]          m_tdata,
    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [MARGIN_W-1:0]  cfg_data,
    output int                   fail_count,
    output int                   pending,
    output int                   reports_checked
);

    localparam int     FRAC      = 8 + EXTRA_FRACTION;
    localparam longint ONE_DB    = longint'(1) <<< FRAC;
    localparam longint COEF_FAST = 3277;
    localparam longint COEF_SLOW = 66;
    localparam longint COUNT_MAX = (longint'(1) <<< COUNT_WIDTH) - 1;
    localparam longint ELAPSED_MAX = (longint'(1) <<< ELAPSED_W) - 1;

    typedef struct {
        logic                 key_on;
        logic [ELAPSED_W-1:0] elapsed;
    } key_report_t;

    key_report_t key_reports[$];

    // block state as predicted
    logic                en;
    logic [MARGIN_W-1:0] margin;
    logic [MARGIN_W-1:0] hyst;
    longint              sig_avg;
    longint              noise_avg;
    longint              low_bnd;
    longint              high_bnd;
    logic                tone_on;
    longint              since_report;

    int errors;
    int checked;

    function automatic longint clamp32(longint v);
        if (v > longint'(32'sh7fffffff)) begin
            return longint'(32'sh7fffffff);
        end else if (v < longint'(32'sh80000000)) begin
            return longint'(32'sh80000000);
        end
        return v;
    endfunction

    // first-order step toward target, floor rounding of the scaled delta
    function automatic longint follow(longint cur, longint target, longint coef);
        return clamp32(cur + (((target - cur) * coef) >>> 16));
    endfunction

    function automatic void absorb_sample(logic rpt, logic signed [15:0] sig_lvl,
                                          logic signed [15:0] noise_lvl);
        longint sig;
        longint noise;
        longint diff;
        longint on_th;
        longint off_th;
        longint mid;
        key_report_t r;
        if (!en) begin
            return;
        end
        if (rpt) begin
            sig       = longint'(sig_lvl) <<< EXTRA_FRACTION;
            noise     = longint'(noise_lvl) <<< EXTRA_FRACTION;
            sig_avg   = clamp32(sig_avg + ((sig - sig_avg) >>> 1));
            noise_avg = follow(noise_avg, noise, COEF_FAST);
            diff      = sig_avg - noise_avg;
            low_bnd   = follow(low_bnd, diff, (low_bnd > diff) ? COEF_FAST : COEF_SLOW);
            high_bnd  = follow(high_bnd, diff, (high_bnd < diff) ? COEF_FAST : COEF_SLOW);
            on_th     = low_bnd + (longint'(margin) <<< EXTRA_FRACTION);
            mid       = (low_bnd + high_bnd) >>> 1;
            if (mid > on_th) begin
                on_th = mid;
            end
            off_th = on_th - (longint'(hyst) <<< EXTRA_FRACTION);
            if (tone_on) begin
                if (diff < off_th) tone_on = 1'b0;
            end else begin
                if (diff > on_th) tone_on = 1'b1;
            end
            r.key_on  = tone_on;
            r.elapsed = (since_report > ELAPSED_MAX) ? ELAPSED_MAX[ELAPSED_W-1:0]
                                                     : since_report[ELAPSED_W-1:0];
            key_reports.push_back(r);
            since_report = 0;
        end
        // the report sample itself counts toward the next run
        if (since_report < COUNT_MAX) since_report++;
    endfunction

    always @(posedge aclk) begin
        key_report_t want;
        if (!aresetn) begin
            en           = 1'b1;
            margin       = SNR_MARGIN_RESET;
            hyst         = HYSTERESIS_RESET;
            sig_avg      = clamp32(-121 * ONE_DB);
            noise_avg    = clamp32(-73 * ONE_DB);
            low_bnd      = clamp32(50 * ONE_DB);
            high_bnd     = clamp32(50 * ONE_DB);
            tone_on      = 1'b0;
            since_report = 0;
            key_reports.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_ENABLE:     en     = cfg_data[0];
                    REG_SNR_MARGIN: margin = cfg_data;
                    REG_HYSTERESIS: hyst   = cfg_data;
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                absorb_sample(s_tlast, s_tdata[15:0], s_tdata[31:16]);
            end
            if (m_tvalid && m_tready) begin
                if (key_reports.size() == 0) begin
                    $error("unexpected result beat: key_on %0d, elapsed_samples %0d",
                           m_tdata[0], m_tdata[16:1]);
                    errors++;
                end else begin
                    want = key_reports.pop_front();
                    checked++;
                    if (m_tdata[0] !== want.key_on) begin
                        $error("key_on mismatch: expected %0d, got %0d",
                               want.key_on, m_tdata[0]);
                        errors++;
                    end
                    if (m_tdata[16:1] !== want.elapsed) begin
                        $error("elapsed_samples mismatch: expected %0d, got %0d",
                               want.elapsed, m_tdata[16:1]);
                        errors++;
                    end
                end
            end
        end
        fail_count      <= errors;
        pending         <= key_reports.size();
        reports_checked <= checked;
    end

endmodule

[test/tb_top.sv]
`timescale 1ns / 100ps
// testbench top of the cw tone keying detector: clock, reset, stimulus and verdict
module tb_top;
    import cwtkd_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int DRAIN_CYCLES = 8;
    localparam int HOLD_CYCLES  = 160;

    logic                 aclk;
    logic                 aresetn   = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [31:0]          s_tdata   = '0;
    logic                 s_tlast   = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [23:0]          m_tdata;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [MARGIN_W-1:0]  cfg_data  = '0;

    int fail_count;
    int pending;
    int reports_checked;

    bit sender_idles = 1'b1;
    bit sink_idles   = 1'b1;
    int hold_id      = 0;
    int samples_sent = 0;
    bit tone_phase   = 1'b0;

    cw_tone_keying_detector_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    cwtkd_checker u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tlast         (s_tlast),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .fail_count      (fail_count),
        .pending         (pending),
        .reports_checked (reports_checked)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    initial begin
        repeat (CYCLE_LIMIT) @(posedge aclk);
        $display("tb_top failed");
        $finish;
    end

    // result side: random stalls per beat, plus a long hold-off on request
    initial begin
        int stall;
        int hold_seen;
        stall     = 0;
        hold_seen = 0;
        forever begin
            @(posedge aclk);
            if (hold_seen != hold_id) begin
                hold_seen = hold_id;
                stall     = HOLD_CYCLES;
            end
            if (stall > 0) begin
                stall--;
                m_tready <= 1'b0;
            end else if (m_tvalid && m_tready) begin
                stall = sink_idles ? $urandom_range(0, 6) : 0;
                if (stall > 0) begin
                    stall--;
                    m_tready <= 1'b0;
                end else begin
                    m_tready <= 1'b1;
                end
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    task automatic send_sample(logic rpt, logic [15:0] sig_lvl, logic [15:0] noise_lvl);
        int gap;
        gap = sender_idles ? $urandom_range(0, 6) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tlast  <= rpt;
        s_tdata  <= {noise_lvl, sig_lvl};
        do @(posedge aclk); while (!s_tready);
        samples_sent++;
    endtask

    // stop offering beats, wait for every report, then let the pipeline settle
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [MARGIN_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // a tone burst or a gap: a few samples around -20 or -110 dB over a -80 dB floor,
    // closed by a report
    task automatic send_keying_group();
        int samples;
        logic [15:0] sig_lvl;
        logic [15:0] noise_lvl;
        if ($urandom_range(0, 3) == 0) tone_phase = !tone_phase;
        samples = $urandom_range(0, 3);
        for (int k = 0; k <= samples; k++) begin
            sig_lvl   = (tone_phase ? -16'sd5120 : -16'sd28160)
                        + 16'($urandom_range(0, 1024)) - 16'sd512;
            noise_lvl = -16'sd20480 + 16'($urandom_range(0, 1024)) - 16'sd512;
            send_sample(k == samples, sig_lvl, noise_lvl);
        end
    endtask

    task automatic random_phase(int n_items);
        int goal;
        goal = samples_sent + n_items;
        while (samples_sent < goal) begin
            if ($urandom_range(0, 15) == 0) sender_idles = !sender_idles;
            if ($urandom_range(0, 15) == 0) sink_idles = !sink_idles;
            if ($urandom_range(0, 3) != 0) begin
                send_keying_group();
            end else begin
                send_sample(1'($urandom_range(0, 1)), 16'($urandom), 16'($urandom));
            end
        end
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: level extremes, report spacing, tone on and off
        send_sample(1'b1, 16'h7fff, 16'h8000);
        send_sample(1'b1, 16'h8000, 16'h7fff);
        send_sample(1'b1, 16'h0000, 16'h0000);
        send_sample(1'b0, 16'h7fff, 16'h7fff);
        send_sample(1'b0, 16'h8000, 16'h8000);
        send_sample(1'b1, 16'h8000, 16'h8000);
        send_sample(1'b1, 16'h7fff, 16'h7fff);
        send_sample(1'b1, 16'hffff, 16'h0001);
        for (int k = 0; k < 6; k++) send_sample(1'b1, -16'sd5120, -16'sd20480);
        for (int k = 0; k < 6; k++) send_sample(1'b1, -16'sd28160, -16'sd20480);
        send_sample(1'b0, 16'h1234, 16'hedcb);
        send_sample(1'b0, 16'h8000, 16'h7fff);
        send_sample(1'b1, 16'h7fff, 16'h8000);

        // result side held off while reports keep coming, input must back up
        sender_idles = 1'b0;
        hold_id++;
        for (int k = 0; k < 24; k++) send_keying_group();
        drain();
        sender_idles = 1'b1;

        // disabled: beats are dropped and the counter holds
        write_reg(REG_ENABLE, 15'h7ffe);
        for (int k = 0; k < 10; k++) send_sample(1'(k % 2), 16'($urandom), 16'($urandom));
        drain();
        write_reg(REG_ENABLE, 15'h7fff);
        write_reg(REG_SPARE, 15'($urandom));
        random_phase(70);
        drain();

        write_reg(REG_SNR_MARGIN, '0);
        write_reg(REG_HYSTERESIS, '0);
        random_phase(70);
        drain();

        write_reg(REG_SNR_MARGIN, 15'h7fff);
        write_reg(REG_HYSTERESIS, 15'h7fff);
        random_phase(70);
        drain();

        write_reg(REG_SNR_MARGIN, 15'($urandom));
        write_reg(REG_HYSTERESIS, 15'($urandom));
        random_phase(70);
        drain();

        write_reg(REG_SNR_MARGIN, 15'd1280);
        write_reg(REG_HYSTERESIS, 15'd512);
        random_phase(40);
        drain();

        $display("run covered %0d samples and %0d checked reports over five register settings,",
                 samples_sent, reports_checked);
        $display("including a disabled phase and a long result stall with the input backed up");
        if (fail_count == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end

endmodule
